/* hw/rtl/rfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    // Receive buffer size in bytes; the byte count saturates here.
    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    // Wide enough for size + 4 without wrap.
    localparam int LEN_W   = WORD_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_VALUE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC_FAILED_CODE = 1'd1;

    localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;

    localparam int OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_CRC    = 3'd3,
        ST_CMD_FAILED = 3'd4
    } t_status;

    // CRC-16/CCITT-FALSE, one byte, MSB first.
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
        logic [WORD_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[WORD_W-1]) begin
                c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rx_frame_checker_crc16.sv */
`timescale 1ns / 1ps
`default_nettype none

// Receive frame checker with CRC-16/CCITT-FALSE.
// Input stream: one received byte per item in s_axis_tdata[7:0], s_axis_tlast on
// the final byte of a transfer. A frame is header (LE16), size (LE16), then size
// bytes: command, result, payload and an LE16 CRC over everything before it.
// Output stream: one item per transfer, issued for the byte that carries tlast,
// with status, command byte, result byte and size field.
// Configuration: i_cfg_we with i_cfg_index 0 writes the expected header word,
// index 1 the result byte that marks a failed command. Write only while idle.
// Throughput: one byte per cycle, except while a byte that carries tlast waits for
// the output register; the CRC is updated a whole byte at a time. Latency: the
// result is valid the cycle after the last byte is taken. The output register
// holds the result while m_axis_tready is low. Bytes keep flowing meanwhile; only
// a byte that carries tlast waits until the output register is empty or being
// drained, so a stalled receiver holds the input only at the end of the next transfer.
// Bytes past the buffer size are dropped and the count saturates.
// Reset (synchronous, active low) clears the transfer state, the configuration
// registers and the output valid.

module rx_frame_checker_crc16 (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rfc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rfc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                               s_axis_tlast,  // last_byte
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [2:0] status, [10:3] cmd_code, [18:11] exec_result, [34:19] frame_size,
    // [39:35] zero
    output      logic [rfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int CW = rfc_pkg::CNT_W;
    localparam int LW = rfc_pkg::LEN_W;
    localparam int WW = rfc_pkg::WORD_W;
    localparam int BW = rfc_pkg::BYTE_W;

    logic [WW-1:0] r_header_value;
    logic [BW-1:0] r_exec_failed_code;

    logic [CW-1:0] r_byte_count, n_byte_count;
    logic [WW-1:0] r_header_seen, n_header_seen;
    logic [WW-1:0] r_size_seen, n_size_seen;
    logic [WW-1:0] r_crc_running, n_crc_running;
    logic [WW-1:0] r_crc_received, n_crc_received;
    logic [BW-1:0] r_cmd_seen, n_cmd_seen;
    logic [BW-1:0] r_result_seen, n_result_seen;

    logic             r_out_valid;
    rfc_pkg::t_status r_status, n_status;
    logic [BW-1:0]    r_out_cmd;
    logic [BW-1:0]    r_out_result;
    logic [WW-1:0]    r_out_size;

    logic          s_fire;
    logic          m_fire;
    logic [BW-1:0] rx_byte;
    logic [LW-1:0] off_ext;
    logic [LW-1:0] frame_len;

    assign rx_byte       = s_axis_tdata[BW-1:0];
    // Only the last byte of a transfer needs room in the output register.
    assign s_axis_tready = !r_out_valid || m_axis_tready || !s_axis_tlast;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = r_out_valid && m_axis_tready;
    assign off_ext       = LW'(r_byte_count);

    // Per-byte state update.
    always_comb begin
        n_byte_count   = r_byte_count;
        n_header_seen  = r_header_seen;
        n_size_seen    = r_size_seen;
        n_crc_running  = r_crc_running;
        n_crc_received = r_crc_received;
        n_cmd_seen     = r_cmd_seen;
        n_result_seen  = r_result_seen;
        if (off_ext < LW'(rfc_pkg::MAX_FRAME_BYTES)) begin
            priority if (off_ext == LW'(0)) begin
                n_header_seen[7:0] = rx_byte;
            end else if (off_ext == LW'(1)) begin
                n_header_seen[15:8] = rx_byte;
            end else if (off_ext == LW'(2)) begin
                n_size_seen[7:0] = rx_byte;
            end else if (off_ext == LW'(3)) begin
                n_size_seen[15:8] = rx_byte;
            end else begin
                n_size_seen = r_size_seen;
            end
            if (off_ext == LW'(4)) begin
                n_cmd_seen = rx_byte;
            end
            if (off_ext == LW'(5)) begin
                n_result_seen = rx_byte;
            end
            // Header and size bytes are always covered; at offset 4 and up the
            // size field is already complete.
            if (off_ext < LW'(4) || off_ext < LW'(r_size_seen) + LW'(2)) begin
                n_crc_running = rfc_pkg::crc_byte(r_crc_running, rx_byte);
            end
            if (off_ext >= LW'(4)) begin
                priority if (off_ext == LW'(r_size_seen) + LW'(2)) begin
                    n_crc_received[7:0] = rx_byte;
                end else if (off_ext == LW'(r_size_seen) + LW'(3)) begin
                    n_crc_received[15:8] = rx_byte;
                end else begin
                    n_crc_received = r_crc_received;
                end
            end
            n_byte_count = r_byte_count + CW'(1);
        end
    end

    // Verdict on the state that includes the current byte.
    assign frame_len = LW'(n_size_seen) + LW'(4);

    always_comb begin
        priority if (n_header_seen != r_header_value) begin
            n_status = rfc_pkg::ST_BAD_HEADER;
        end else if (n_size_seen < WW'(2) || frame_len > LW'(n_byte_count)
                     || frame_len > LW'(rfc_pkg::MAX_FRAME_BYTES)) begin
            n_status = rfc_pkg::ST_BAD_LENGTH;
        end else if (n_crc_received != n_crc_running) begin
            n_status = rfc_pkg::ST_BAD_CRC;
        end else if (n_result_seen == r_exec_failed_code) begin
            n_status = rfc_pkg::ST_CMD_FAILED;
        end else begin
            n_status = rfc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_value     <= '0;
            r_exec_failed_code <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rfc_pkg::CFG_HEADER_VALUE:     r_header_value     <= i_cfg_wdata[WW-1:0];
                rfc_pkg::CFG_EXEC_FAILED_CODE: r_exec_failed_code <= i_cfg_wdata[BW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_header_seen  <= '0;
            r_size_seen    <= '0;
            r_crc_running  <= rfc_pkg::CRC_INIT;
            r_crc_received <= '0;
            r_cmd_seen     <= '0;
            r_result_seen  <= '0;
        end else if (s_fire) begin
            if (s_axis_tlast) begin
                // Start the next transfer from scratch.
                r_byte_count   <= '0;
                r_header_seen  <= '0;
                r_size_seen    <= '0;
                r_crc_running  <= rfc_pkg::CRC_INIT;
                r_crc_received <= '0;
                r_cmd_seen     <= '0;
                r_result_seen  <= '0;
            end else begin
                r_byte_count   <= n_byte_count;
                r_header_seen  <= n_header_seen;
                r_size_seen    <= n_size_seen;
                r_crc_running  <= n_crc_running;
                r_crc_received <= n_crc_received;
                r_cmd_seen     <= n_cmd_seen;
                r_result_seen  <= n_result_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire && s_axis_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && s_axis_tlast) begin
            r_status     <= n_status;
            r_out_cmd    <= n_cmd_seen;
            r_out_result <= n_result_seen;
            r_out_size   <= n_size_seen;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_size, r_out_result, r_out_cmd, r_status};

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && s_axis_tlast |=> r_out_valid)
        else $error("no result after last byte");

    a_state_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && s_axis_tlast |=> r_byte_count == '0 && r_crc_running == rfc_pkg::CRC_INIT)
        else $error("transfer state not cleared after last byte");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_byte_count) <= LW'(rfc_pkg::MAX_FRAME_BYTES))
        else $error("byte count past buffer size");

    a_no_drop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready && s_axis_tlast |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_status_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_status <= rfc_pkg::ST_CMD_FAILED)
        else $error("status code out of range");

endmodule

`default_nettype wire
